[rtl/sll_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sll_pkg
// Shared types, codes and reset constants of the session lease lock.
// ----------------------------------------------------------------------------
package sll_pkg;

  localparam int unsigned TimeW = 32;
  localparam int unsigned IdW   = 32;
  localparam int unsigned CfgW  = 32;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [TimeW-1:0] LeaseDefaultMs = 32'd5000;
  localparam logic [TimeW-1:0] LeaseMaxMs     = 32'd600000;

  // request modes
  localparam logic [2:0] ModeOpen   = 3'd0;
  localparam logic [2:0] ModeAccess = 3'd1;
  localparam logic [2:0] ModeEnd    = 3'd2;
  localparam logic [2:0] ModeQuery  = 3'd3;
  localparam logic [2:0] ModeTick   = 3'd4;

  // result status
  localparam logic [1:0] StDone      = 2'd0;
  localparam logic [1:0] StSessReq   = 2'd1;
  localparam logic [1:0] StNoSession = 2'd2;
  localparam logic [1:0] StLocked    = 2'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] RegLeaseDefault = 2'd0;
  localparam logic [CfgIdxW-1:0] RegLeaseMax     = 2'd1;
  localparam logic [CfgIdxW-1:0] RegBootId       = 2'd2;

  typedef struct packed {
    logic [2:0]       mode;
    logic [TimeW-1:0] now_ms;
    logic             sid_present;
    logic [IdW-1:0]   req_sid;
    logic [TimeW-1:0] requested_lease_ms;
    logic             force_req;
  } item_t;

  typedef struct packed {
    logic             locked;
    logic [IdW-1:0]   holder_id;
    logic [IdW-1:0]   last_id;
    logic             last_valid;
    logic [TimeW-1:0] expiry_time;
    logic [TimeW-1:0] lease_length;
  } state_t;

  typedef struct packed {
    logic [TimeW-1:0] lease_default_ms;
    logic [TimeW-1:0] lease_max_ms;
    logic [IdW-1:0]   boot_id;
  } cfg_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [TimeW-1:0] lease_left_ms;
    logic [TimeW-1:0] granted_lease_ms;
    logic [IdW-1:0]   reported_boot_id;
    logic             resumed;
    logic             is_locked;
    logic             ended_subscriptions;
  } result_t;

endpackage
`default_nettype wire

[rtl/sll_step.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// sll_step
// Next-state and result logic for one request against the lock state.
// ----------------------------------------------------------------------------
module sll_step (
  input  var sll_pkg::item_t   item_i,
  input  var sll_pkg::state_t  state_i,
  input  var sll_pkg::cfg_t    cfg_i,
  output sll_pkg::state_t      state_o,
  output sll_pkg::result_t     result_o
);

  logic                        locked_lp;
  logic                        lapse;
  logic [sll_pkg::TimeW-1:0]   since_exp;
  logic [sll_pkg::TimeW-1:0]   to_exp;
  logic [sll_pkg::TimeW-1:0]   time_left;
  logic                        id_is_holder;
  logic                        id_is_last;
  logic                        other_holds;
  logic                        open_taken;
  logic                        is_req;
  logic                        renew;
  logic [sll_pkg::TimeW-1:0]   lease_clamped;
  logic [sll_pkg::TimeW-1:0]   exp_new;
  logic [1:0]                  chk_status;
  logic                        chk_resume;
  sll_pkg::state_t             st;
  sll_pkg::result_t            res;

  // lease lapses once now has reached expiry (wrapping signed compare)
  assign since_exp = item_i.now_ms - state_i.expiry_time;
  assign lapse     = state_i.locked && !since_exp[sll_pkg::TimeW-1];
  assign locked_lp = state_i.locked && !lapse;

  assign to_exp    = state_i.expiry_time - item_i.now_ms;
  assign time_left = (locked_lp && (to_exp != '0) && !to_exp[sll_pkg::TimeW-1]) ? to_exp : '0;

  assign id_is_holder = (item_i.req_sid == state_i.holder_id);
  assign id_is_last   = state_i.last_valid && (item_i.req_sid == state_i.last_id);
  assign other_holds  = locked_lp && !id_is_holder;

  assign lease_clamped = (item_i.requested_lease_ms == '0) ? cfg_i.lease_default_ms :
                         (item_i.requested_lease_ms > cfg_i.lease_max_ms) ? cfg_i.lease_max_ms :
                         item_i.requested_lease_ms;

  // access check shared by access and end
  always_comb begin
    chk_resume = 1'b0;
    if (!item_i.sid_present) begin
      chk_status = sll_pkg::StSessReq;
    end else if (!locked_lp) begin
      if (id_is_last) begin
        chk_status = sll_pkg::StDone;
        chk_resume = 1'b1;
      end else begin
        chk_status = sll_pkg::StNoSession;
      end
    end else if (id_is_holder) begin
      chk_status = sll_pkg::StDone;
    end else begin
      chk_status = sll_pkg::StLocked;
    end
  end

  always_comb begin
    st          = state_i;
    st.locked   = locked_lp;
    open_taken  = 1'b0;
    res         = '0;
    res.status  = sll_pkg::StDone;
    res.ended_subscriptions = lapse;
    case (item_i.mode)
      sll_pkg::ModeOpen: begin
        if (other_holds && !item_i.force_req) begin
          res.status        = sll_pkg::StLocked;
          res.lease_left_ms = time_left;
        end else begin
          open_taken   = 1'b1;
          res.ended_subscriptions = lapse | other_holds;
          res.resumed  = (locked_lp && id_is_holder) || id_is_last;
          st.locked     = 1'b1;
          st.holder_id  = item_i.req_sid;
          st.last_id    = item_i.req_sid;
          st.last_valid = 1'b1;
          st.lease_length      = lease_clamped;
          res.granted_lease_ms = lease_clamped;
          res.reported_boot_id = cfg_i.boot_id;
        end
      end
      sll_pkg::ModeAccess, sll_pkg::ModeEnd: begin
        res.status = chk_status;
        if (chk_status == sll_pkg::StLocked) begin
          res.lease_left_ms = time_left;
        end
        if (chk_resume) begin
          st.locked    = 1'b1;
          st.holder_id = item_i.req_sid;
        end
        if ((item_i.mode == sll_pkg::ModeEnd) && (chk_status == sll_pkg::StDone)) begin
          st.locked = 1'b0;
          res.ended_subscriptions = 1'b1;
        end
      end
      sll_pkg::ModeQuery: begin
        res.lease_left_ms = time_left;
      end
      default: begin
        // tick and unused modes only lapse
      end
    endcase

    is_req = (item_i.mode == sll_pkg::ModeOpen) || (item_i.mode == sll_pkg::ModeAccess) ||
             (item_i.mode == sll_pkg::ModeEnd) || (item_i.mode == sll_pkg::ModeQuery);
    renew  = is_req && item_i.sid_present && st.locked && (item_i.req_sid == st.holder_id);
    // open and renewal both place expiry one lease after now
    exp_new = item_i.now_ms + st.lease_length;
    if (open_taken || renew) begin
      st.expiry_time = exp_new;
    end
    res.is_locked = st.locked;
  end

  assign state_o  = st;
  assign result_o = res;

endmodule
`default_nettype wire

[rtl/session_lease_lock.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// session_lease_lock
// Leased exclusive lock owned by a 32-bit session id, one request per beat.
// ----------------------------------------------------------------------------
// Takes one request beat every clock cycle unless stalled. A request goes into
// an input register, is evaluated in a single pass of compare/add logic
// against the lock state, and its result beat is offered from the output
// register. State updates with the result, so back-to-back requests see each
// other's effect. The user must write configuration through the plain write
// port while no request is in flight; the block does not enforce this.
module session_lease_lock #(
  parameter logic [31:0] LEASE_DEFAULT_RST = sll_pkg::LeaseDefaultMs,
  parameter logic [31:0] LEASE_MAX_RST     = sll_pkg::LeaseMaxMs
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  // configuration
  input  wire                        cfg_we_i,
  input  wire [sll_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire [sll_pkg::CfgW-1:0]    cfg_wdata_i,
  // request channel
  input  wire                        in_valid_i,
  output logic                       in_stall_o,
  input  wire [2:0]                  mode_i,
  input  wire [31:0]                 now_ms_i,
  input  wire                        sid_present_i,
  input  wire [31:0]                 req_sid_i,
  input  wire [31:0]                 requested_lease_ms_i,
  input  wire                        force_req_i,
  // result channel
  output logic                       out_valid_o,
  input  wire                        out_stall_i,
  output logic [1:0]                 status_o,
  output logic [31:0]                lease_left_ms_o,
  output logic [31:0]                granted_lease_ms_o,
  output logic [31:0]                reported_boot_id_o,
  output logic                       resumed_o,
  output logic                       is_locked_o,
  output logic                       ended_subscriptions_o
);

  sll_pkg::cfg_t    cfg_q;
  sll_pkg::state_t  state_q, state_d;
  sll_pkg::item_t   item_q;
  sll_pkg::result_t res_d, res_q;
  logic             in_vld_q;
  logic             out_vld_q;
  logic             adv;
  logic             fire;

  assign adv        = !out_vld_q || !out_stall_i;
  assign fire       = adv && in_vld_q;
  assign in_stall_o = in_vld_q && !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lease_default_ms <= LEASE_DEFAULT_RST;
      cfg_q.lease_max_ms     <= LEASE_MAX_RST;
      cfg_q.boot_id          <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sll_pkg::RegLeaseDefault: cfg_q.lease_default_ms <= cfg_wdata_i;
        sll_pkg::RegLeaseMax:     cfg_q.lease_max_ms     <= cfg_wdata_i;
        sll_pkg::RegBootId:       cfg_q.boot_id          <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) begin
      item_q.mode               <= mode_i;
      item_q.now_ms             <= now_ms_i;
      item_q.sid_present        <= sid_present_i;
      item_q.req_sid            <= req_sid_i;
      item_q.requested_lease_ms <= requested_lease_ms_i;
      item_q.force_req          <= force_req_i;
    end
  end

  sll_step u_step (
    .item_i   (item_q),
    .state_i  (state_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (fire) begin
      state_q <= state_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o           = out_vld_q;
  assign status_o              = res_q.status;
  assign lease_left_ms_o       = res_q.lease_left_ms;
  assign granted_lease_ms_o    = res_q.granted_lease_ms;
  assign reported_boot_id_o    = res_q.reported_boot_id;
  assign resumed_o             = res_q.resumed;
  assign is_locked_o           = res_q.is_locked;
  assign ended_subscriptions_o = res_q.ended_subscriptions;

  a_fire_gives_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_vld_q)
    else $error("evaluated request did not produce a result beat");

  a_lock_flag_tracks_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> (res_q.is_locked == state_q.locked))
    else $error("reported lock flag differs from lock state");

  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.status != sll_pkg::StDone)) |->
      ((res_q.granted_lease_ms == '0) && (res_q.reported_boot_id == '0) && !res_q.resumed))
    else $error("rejected request carries open results");

  a_locked_status_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && (res_q.status == sll_pkg::StLocked)) |-> res_q.is_locked)
    else $error("locked-by-other status without a held lock");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> $stable(state_q))
    else $error("lock state changed without an evaluated request");

endmodule
`default_nettype wire
